FILE: rtl/wbs_pkg.sv
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared types and codes for the word break segmenter core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package wbs_pkg;

    typedef enum logic [1:0] {
        OP_DICT  = 2'd0,
        OP_TEXT  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // Control from the core to every word cell
    typedef struct packed {
        logic shift;   // shift a dictionary character into the cell
        logic commit;  // the word in the cell is complete
        logic clear;   // forget the stored word
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/word_break_segmenter_core.sv
// ----------------------------------------------------------------------------
// word_break_segmenter_core
// Streaming word break recognizer: a row of word cells, one per dictionary
// word, checks each text character against a window of recent characters.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                      payload
//  in       input      i_in_valid / o_in_stall        i_op, i_ch, i_last
//  out      output     o_out_valid / i_out_stall      o_prefix_ok, o_text_done,
//                                                     o_status
//
//  One transaction per cycle; its result appears in the output register on
//  the next cycle. The path that sets the clock is the window compare in a
//  cell plus the hit chain through all WORDS cells into the reach register.
//  Reset is synchronous and immediate; no clearing pass is needed.
//  A stalled output holds, and the input stalls only while it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module word_break_segmenter_core
    import wbs_pkg::*;
#(
    parameter int WORDS   = 16,
    parameter int MAX_LEN = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_prefix_ok,
    output logic            o_text_done,
    output logic [1:0]      o_status
);

    localparam int WCW = $clog2(WORDS + 1);
    localparam int LLW = $clog2(MAX_LEN + 1);
    localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [WCW-1:0]          r_word_count, n_word_count;
    logic [LLW-1:0]          r_load_len,   n_load_len;
    logic                    r_overflow,   n_overflow;
    logic [MAX_LEN-1:0]      r_reach,      n_reach;
    logic [MAX_LEN-1:0][7:0] r_window,     n_window;
    logic                    r_out_valid;
    logic                    r_prefix_ok,  n_prefix_ok;
    logic                    r_text_done,  n_text_done;
    t_status                 r_status,     n_status;

    logic                    w_accept;
    logic                    w_shift, w_commit, w_clear;
    logic [MAX_LEN-1:0][7:0] w_window_next;
    logic [MAX_LEN:0]        w_reach_shift;
    logic [WORDS:0]          w_hit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Window with the incoming character at position 0
    always_comb begin
        w_window_next[0] = i_ch;
        for (int k = 1; k < MAX_LEN; k++) begin
            w_window_next[k] = r_window[k-1];
        end
    end

    assign w_reach_shift = {r_reach, w_hit[WORDS]};

    always_comb begin
        n_word_count = r_word_count;
        n_load_len   = r_load_len;
        n_overflow   = r_overflow;
        n_reach      = r_reach;
        n_window     = r_window;
        n_prefix_ok  = 1'b0;
        n_text_done  = 1'b0;
        n_status     = ST_OK;
        w_shift      = 1'b0;
        w_commit     = 1'b0;
        w_clear      = 1'b0;
        unique case (t_op'(i_op))
            OP_DICT: begin
                if (r_word_count == WCW'(WORDS)) begin
                    n_status = ST_FULL;
                end else if (r_overflow || (r_load_len >= LLW'(MAX_LEN))) begin
                    n_status   = ST_TOO_LONG;
                    n_overflow = 1'b1;
                end else begin
                    w_shift    = 1'b1;
                    n_load_len = r_load_len + 1'b1;
                end
                if (i_last) begin
                    if (n_status == ST_OK) begin
                        w_commit     = 1'b1;
                        n_word_count = r_word_count + 1'b1;
                    end
                    n_load_len = '0;
                    n_overflow = 1'b0;
                end
            end
            OP_TEXT: begin
                n_prefix_ok = w_hit[WORDS];
                n_text_done = i_last;
                if (i_last) begin
                    n_reach  = MAX_LEN'(1);
                    n_window = '0;
                end else begin
                    n_reach  = w_reach_shift[MAX_LEN-1:0];
                    n_window = w_window_next;
                end
            end
            OP_CLEAR: begin
                w_clear      = 1'b1;
                n_word_count = '0;
                n_load_len   = '0;
                n_overflow   = 1'b0;
                n_reach      = MAX_LEN'(1);
                n_window     = '0;
            end
            default: begin
                // unused op: no state change, all-zero result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= '0;
            r_load_len   <= '0;
            r_overflow   <= 1'b0;
            r_reach      <= MAX_LEN'(1);
            r_window     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_word_count <= n_word_count;
                r_load_len   <= n_load_len;
                r_overflow   <= n_overflow;
                r_reach      <= n_reach;
                r_window     <= n_window;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prefix_ok <= n_prefix_ok;
            r_text_done <= n_text_done;
            r_status    <= n_status;
        end
    end

    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < WORDS; g++) begin : g_cell
        t_cell_ctl w_ctl;

        // Only the cell at the fill position takes dictionary characters
        always_comb begin
            w_ctl.shift  = w_accept && w_shift  && (r_word_count == WCW'(g));
            w_ctl.commit = w_accept && w_commit && (r_word_count == WCW'(g));
            w_ctl.clear  = w_accept && w_clear;
        end

        wbs_cell #(
            .MAX_LEN (MAX_LEN),
            .LW      (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_ch     (i_ch),
            .i_len_m1 (r_load_len[LW-1:0]),
            .i_window (w_window_next),
            .i_reach  (r_reach),
            .i_hit    (w_hit[g]),
            .o_hit    (w_hit[g+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_prefix_ok = r_prefix_ok;
    assign o_text_done = r_text_done;
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_count <= WCW'(WORDS))
        else $error("word count beyond dictionary size");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_len <= LLW'(MAX_LEN))
        else $error("load length beyond maximum word length");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_CLEAR)) |=> (r_word_count == '0))
        else $error("dictionary not emptied by clear");

    a_text_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_TEXT) && i_last) |=> (r_reach == MAX_LEN'(1)))
        else $error("reach history not restarted at text end");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_prefix_ok || o_text_done)) |-> (o_status == ST_OK))
        else $error("text result carries a dictionary status");

endmodule

`default_nettype wire

FILE: rtl/wbs_cell.sv
// ----------------------------------------------------------------------------
// wbs_cell
// One dictionary word: stores its characters newest first and its length,
// matches them against the text window and ORs its hit into the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_cell
    import wbs_pkg::*;
#(
    parameter int MAX_LEN = 16,
    parameter int LW      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cell_ctl                   i_ctl,
    input  wire logic [7:0]                  i_ch,
    input  wire logic [LW-1:0]               i_len_m1,
    input  wire logic [MAX_LEN-1:0][7:0]     i_window,
    input  wire logic [MAX_LEN-1:0]          i_reach,
    input  wire logic                        i_hit,
    output logic                             o_hit
);

    logic [MAX_LEN-1:0][7:0] r_chars;
    logic [LW-1:0]           r_len_m1;
    logic                    r_valid;
    logic [MAX_LEN-1:0]      w_match;
    logic                    w_own_hit;

    // Position 0 holds the last character of the word, as the window does.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_chars[0] <= i_ch;
            for (int k = 1; k < MAX_LEN; k++) begin
                r_chars[k] <= r_chars[k-1];
            end
        end
        if (i_ctl.commit) begin
            r_len_m1 <= i_len_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_valid <= 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            w_match[k] = (r_chars[k] == i_window[k]) || (LW'(k) > r_len_m1);
        end
        w_own_hit = r_valid && i_reach[r_len_m1] && (&w_match);
    end

    assign o_hit = i_hit | w_own_hit;

endmodule

`default_nettype wire

FILE: tb/sv/word_break_segmenter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_break_segmenter_core_tb
// Loads dictionaries and streams texts into the segmenter, predicts every
// verdict with a behavioral model kept in the bench, and compares each output
// transaction field by field under random idling and a long output hold.
// ----------------------------------------------------------------------------

module word_break_segmenter_core_tb
    import wbs_pkg::*;
();

    localparam int WORDS          = 16;
    localparam int MAX_LEN        = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PRESSURE_ITEMS = 40;

    // op code 3 is not defined by the block and must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic    prefix_ok;
        logic    text_done;
        t_status status;
    } t_seg_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_op;
    logic [7:0] i_ch;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_prefix_ok;
    logic       o_text_done;
    logic [1:0] o_status;

    word_break_segmenter_core #(
        .WORDS   (WORDS),
        .MAX_LEN (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prefix_ok (o_prefix_ok),
        .o_text_done (o_text_done),
        .o_status    (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Segmenter state as the bench sees it
    logic [7:0]         dict_chars [WORDS][MAX_LEN];
    int                 dict_len [WORDS];
    int                 dict_count;
    int                 pend_len;
    bit                 pend_over;
    logic [7:0]         text_window [MAX_LEN];
    logic [MAX_LEN-1:0] reach_bits;

    t_seg_verdict pending_verdicts[$];

    int send_idle_pct;
    int recv_idle_pct;
    int sent_items;
    int verdicts_checked;
    int mismatches;
    int hold_asked;
    int hold_served;
    int hold_left;

    logic [7:0] alphabet [3];

    function automatic void restart_text_model();
        for (int k = 0; k < MAX_LEN; k++) text_window[k] = 8'h00;
        reach_bits = MAX_LEN'(1);
    endfunction

    function automatic t_seg_verdict predict_verdict(logic [1:0] op, logic [7:0] ch,
                                                     logic last);
        t_seg_verdict res;
        int           len;
        bit           same;
        bit           hit;
        res.prefix_ok = 1'b0;
        res.text_done = 1'b0;
        res.status    = ST_OK;
        case (op)
            OP_DICT: begin
                if (dict_count >= WORDS) begin
                    res.status = ST_FULL;
                end else if (pend_over || pend_len >= MAX_LEN) begin
                    pend_over  = 1'b1;
                    res.status = ST_TOO_LONG;
                end else begin
                    dict_chars[dict_count][pend_len] = ch;
                    pend_len++;
                end
                if (last) begin
                    if (res.status == ST_OK) begin
                        dict_len[dict_count] = pend_len;
                        dict_count++;
                    end
                    pend_len  = 0;
                    pend_over = 1'b0;
                end
            end
            OP_TEXT: begin
                for (int k = MAX_LEN - 1; k > 0; k--) text_window[k] = text_window[k-1];
                text_window[0] = ch;
                hit = 1'b0;
                for (int w = 0; w < dict_count; w++) begin
                    len = dict_len[w];
                    // a word matches only if the prefix before it was reachable
                    if (len >= 1 && len <= MAX_LEN && reach_bits[len-1]) begin
                        same = 1'b1;
                        for (int k = 0; k < len; k++)
                            if (dict_chars[w][len-1-k] != text_window[k]) same = 1'b0;
                        if (same) hit = 1'b1;
                    end
                end
                reach_bits    = {reach_bits[MAX_LEN-2:0], hit};
                res.prefix_ok = hit;
                if (last) begin
                    res.text_done = 1'b1;
                    restart_text_model();
                end
            end
            OP_CLEAR: begin
                dict_count = 0;
                pend_len   = 0;
                pend_over  = 1'b0;
                restart_text_model();
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_val);
        $display("%0t: verdict %0d %s: got %0d, want %0d",
                 $time, verdicts_checked, what, got, want_val);
        mismatches++;
    endtask

    // Offer one transaction, hold it until accepted, then predict its verdict
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_ch       <= ch;
        i_last     <= last;
        do @(posedge i_clk); while (o_in_stall);
        pending_verdicts.push_back(predict_verdict(op, ch, last));
        if (op != OP_UNUSED) sent_items++;
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return alphabet[$urandom_range(0, 2)];
    endfunction

    task automatic load_word(input int len);
        for (int k = 0; k < len; k++)
            send_item(OP_DICT, pick_char(), k == len - 1);
    endtask

    task automatic send_word_as_text(input int w, input logic last);
        int len;
        len = dict_len[w];
        for (int k = 0; k < len; k++)
            send_item(OP_TEXT, dict_chars[w][k], last && (k == len - 1));
    endtask

    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_seg_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_prefix_ok !== want.prefix_ok)
                    report_mismatch("prefix_ok", int'(o_prefix_ok), int'(want.prefix_ok));
                if (o_text_done !== want.text_done)
                    report_mismatch("text_done", int'(o_text_done), int'(want.text_done));
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
            end
            verdicts_checked++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_directed_cases();
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        send_item(OP_CLEAR, 8'h00, 1'b0);
        send_item(OP_DICT, 8'h00, 1'b1);
        send_item(OP_DICT, 8'hFF, 1'b0);
        send_item(OP_DICT, 8'h41, 1'b1);
        // first character cannot end a two-character word
        send_item(OP_TEXT, 8'hFF, 1'b0);
        send_item(OP_TEXT, 8'h41, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b1);
        send_item(OP_TEXT, 8'h00, 1'b1);
        // grow the dictionary in the middle of a text
        send_item(OP_TEXT, 8'h41, 1'b0);
        send_item(OP_DICT, 8'h41, 1'b1);
        send_item(OP_TEXT, 8'h41, 1'b1);
        send_item(OP_CLEAR, 8'hFF, 1'b1);
        send_item(OP_TEXT, 8'h00, 1'b1);
    endtask

    task automatic test_dictionary_limits();
        send_item(OP_CLEAR, 8'h00, 1'b0);
        load_word(MAX_LEN + 2);
        load_word(MAX_LEN);
        send_word_as_text(dict_count - 1, 1'b1);
        for (int w = 1; w < WORDS; w++) load_word(1);
        send_item(OP_DICT, 8'hFF, 1'b0);
        send_item(OP_DICT, 8'h00, 1'b1);
        for (int k = 0; k < 3; k++) send_item(OP_TEXT, pick_char(), k == 2);
        send_item(OP_CLEAR, 8'h00, 1'b0);
    endtask

    task automatic test_random_sessions(input int n_items);
        int goal;
        int r;
        int pieces;
        bit broken;
        goal = sent_items + n_items;
        for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom);
        while (sent_items < goal) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
            end else if (r < 7 || (dict_count == WORDS && r < 30)) begin
                send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
            end else if (dict_count == 0 || r < 32) begin
                if ($urandom_range(0, 99) < 8)
                    load_word($urandom_range(MAX_LEN - 1, MAX_LEN + 3));
                else
                    load_word($urandom_range(1, 4));
            end else begin
                pieces = $urandom_range(1, 6);
                broken = ($urandom_range(0, 9) == 0);
                for (int p = 0; p < pieces; p++) begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        send_word_as_text($urandom_range(0, dict_count - 1),
                                          (p == pieces - 1) && !broken);
                    else if (r < 92)
                        send_item(OP_TEXT, pick_char(), (p == pieces - 1) && !broken);
                    else
                        load_word($urandom_range(1, 3));
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        int saved_pct;
        int goal;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_asked++;
        load_word(2);
        goal = sent_items + PRESSURE_ITEMS;
        while (sent_items < goal)
            send_word_as_text($urandom_range(0, dict_count - 1), $urandom_range(0, 2) == 0);
        send_idle_pct = saved_pct;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_op             = OP_DICT;
        i_ch             = 8'h00;
        i_last           = 1'b0;
        send_idle_pct    = 27;
        recv_idle_pct    = 60;
        sent_items       = 0;
        verdicts_checked = 0;
        mismatches       = 0;
        hold_asked       = 0;
        hold_served      = 0;
        hold_left        = 0;
        dict_count       = 0;
        pend_len         = 0;
        pend_over        = 1'b0;
        for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom);
        restart_text_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_dictionary_limits();
        test_random_sessions(110);

        send_idle_pct = 60;
        recv_idle_pct = 27;
        test_random_sessions(110);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sessions(110);

        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
